>>> rtl/core/tfxd_pkg.sv
// Shared types and constants for the TLV frame deframer with XOR check byte.
package tfxd_pkg;

    localparam int unsigned KIND_W     = 3;
    localparam int unsigned KIND_COUNT = 6;
    localparam int unsigned BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] TYPE_FIRST = 8'h20;
    localparam logic [BYTE_W-1:0] TYPE_LAST  = 8'h25;

    localparam logic [KIND_W-1:0] KIND_TEMP     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FUEL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BATTERY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SPEED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ANTILOCK = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SEATBELT = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              mismatch;
        logic [BYTE_W-1:0] value;
    } frame_evt_t;

    typedef logic [KIND_COUNT-1:0][BYTE_W-1:0] reading_vec_t;

endpackage

>>> rtl/core/tfxd_front.sv
// Front end: byte parser that tracks frame phase and checksum and emits one event per frame.
module tfxd_front
    import tfxd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic              q_full,
    output logic              evt_push,
    output frame_evt_t        evt_data
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] last_reg, last_next;
    logic              accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        xor_next   = xor_reg;
        last_next  = last_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_rx_byte >= TYPE_FIRST && s_rx_byte <= TYPE_LAST) begin
                        kind_next  = KIND_W'(s_rx_byte - TYPE_FIRST);
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    xor_next   = s_rx_byte;
                    left_next  = s_rx_byte;
                    last_next  = '0;
                    phase_next = (s_rx_byte == '0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    xor_next  = xor_reg ^ s_rx_byte;
                    last_next = s_rx_byte;
                    left_next = left_reg - 1'b1;
                    if (left_reg == 8'd1) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    assign evt_push          = accept && (phase_reg == PH_CHECK);
    assign evt_data.kind     = kind_reg;
    assign evt_data.mismatch = (xor_reg != s_rx_byte);
    assign evt_data.value    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            kind_reg  <= '0;
            left_reg  <= '0;
            xor_reg   <= '0;
            last_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            xor_reg   <= xor_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> rtl/core/tfxd_queue.sv
// Small event queue that decouples the frame parser from the reading store.
module tfxd_queue
    import tfxd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_evt_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output frame_evt_t pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    frame_evt_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/tfxd_back.sv
// Back end: applies frame events to the reading store and holds the result register.
module tfxd_back
    import tfxd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              evt_valid,
    input  frame_evt_t        evt_data,
    output logic              evt_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_frame_kind,
    output logic              m_frame_status,
    output reading_vec_t      m_readings
);

    reading_vec_t      store_reg, store_next;
    logic              valid_reg, valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic              status_reg;

    assign evt_pop = evt_valid && (!valid_reg || m_ready);

    always_comb begin
        store_next = store_reg;
        if (!evt_data.mismatch && (evt_data.kind < KIND_W'(KIND_COUNT))) begin
            store_next[evt_data.kind] = evt_data.value;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (evt_pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            store_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (evt_pop) begin
                store_reg <= store_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_pop) begin
            kind_reg   <= evt_data.kind;
            status_reg <= evt_data.mismatch;
        end
    end

    assign m_valid        = valid_reg;
    assign m_frame_kind   = kind_reg;
    assign m_frame_status = status_reg;
    assign m_readings     = store_reg;

endmodule

>>> rtl/core/tlv_frame_xor_deframer_unit.sv
// Top level of the TLV frame deframer with XOR check byte.
// The block takes one received byte per cycle on the s_ channel and never stalls it while the
// event queue has room. A frame is a type byte from 0x20 to 0x25, a length byte, that many
// payload bytes and a check byte; other bytes outside a frame are dropped. The check byte's
// transfer produces one result on the m_ channel, passed through the event queue and the
// back end's result register, carrying the frame kind, the checksum status and all six held
// readings after the frame. While the m_ side keeps up, bytes flow at one per cycle; up to
// QUEUE_DEPTH finished frames wait in the queue while the m_ side stalls.
module tlv_frame_xor_deframer_unit
    import tfxd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_frame_kind,
    output logic              m_frame_status,
    output logic [BYTE_W-1:0] m_temp_value,
    output logic [BYTE_W-1:0] m_fuel_value,
    output logic [BYTE_W-1:0] m_battery_value,
    output logic [BYTE_W-1:0] m_speed_value,
    output logic [BYTE_W-1:0] m_antilock_flag,
    output logic [BYTE_W-1:0] m_seatbelt_flag
);

    logic         q_full;
    logic         evt_push;
    frame_evt_t   evt_in;
    logic         evt_pop;
    logic         evt_valid;
    frame_evt_t   evt_out;
    reading_vec_t readings;

    tfxd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .evt_push  (evt_push),
        .evt_data  (evt_in)
    );

    tfxd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_push),
        .push_data (evt_in),
        .full      (q_full),
        .pop       (evt_pop),
        .not_empty (evt_valid),
        .pop_data  (evt_out)
    );

    tfxd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .evt_valid      (evt_valid),
        .evt_data       (evt_out),
        .evt_pop        (evt_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_frame_status (m_frame_status),
        .m_readings     (readings)
    );

    assign m_temp_value    = readings[KIND_TEMP];
    assign m_fuel_value    = readings[KIND_FUEL];
    assign m_battery_value = readings[KIND_BATTERY];
    assign m_speed_value   = readings[KIND_SPEED];
    assign m_antilock_flag = readings[KIND_ANTILOCK];
    assign m_seatbelt_flag = readings[KIND_SEATBELT];

endmodule

>>> rtl/core/tfxd_checker.sv
// Port-level assertions for the TLV frame deframer, bound to the top level.
module tfxd_checker
    import tfxd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [KIND_W-1:0] m_frame_kind,
    input logic              m_frame_status,
    input logic [BYTE_W-1:0] m_temp_value,
    input logic [BYTE_W-1:0] m_fuel_value,
    input logic [BYTE_W-1:0] m_battery_value,
    input logic [BYTE_W-1:0] m_speed_value,
    input logic [BYTE_W-1:0] m_antilock_flag,
    input logic [BYTE_W-1:0] m_seatbelt_flag
);

    // A stalled result keeps its valid and every payload field.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_kind) && $stable(m_frame_status)
            && $stable(m_temp_value) && $stable(m_fuel_value) && $stable(m_battery_value)
            && $stable(m_speed_value) && $stable(m_antilock_flag) && $stable(m_seatbelt_flag))
        else $error("Result changed while stalled.");

    // A new result only follows an earlier input transfer.
    a_result_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("Result appeared without a preceding input transfer.");

    // Frame kinds come only from the six type bytes.
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_kind <= KIND_SEATBELT))
        else $error("Result carries an unknown frame kind.");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

endmodule

bind tlv_frame_xor_deframer_unit tfxd_checker u_tfxd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_frame_kind    (m_frame_kind),
    .m_frame_status  (m_frame_status),
    .m_temp_value    (m_temp_value),
    .m_fuel_value    (m_fuel_value),
    .m_battery_value (m_battery_value),
    .m_speed_value   (m_speed_value),
    .m_antilock_flag (m_antilock_flag),
    .m_seatbelt_flag (m_seatbelt_flag)
);

>>> tb/tlv_frame_xor_deframer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the TLV frame deframer: byte stimulus, frame predictor, result checks.
module tlv_frame_xor_deframer_unit_tb;
    import tfxd_pkg::*;

    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned TARGET_BYTES   = 1700;
    localparam int unsigned DRAIN_INTERVAL = 400;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    localparam logic STATUS_MATCH    = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    typedef enum logic [1:0] {
        SEEK_TYPE,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_CHECK
    } deframe_phase_t;

    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic              status;
        reading_vec_t      readings;
    } frame_result_t;

    class frame_scoreboard;
        deframe_phase_t    phase;
        logic [KIND_W-1:0] kind_held;
        logic [BYTE_W-1:0] bytes_left;
        logic [BYTE_W-1:0] running_xor;
        logic [BYTE_W-1:0] last_payload;
        reading_vec_t      held_readings;
        frame_result_t     expected_q[$];
        int unsigned       errors;
        string             reading_names[KIND_COUNT] = '{"temp_value", "fuel_value",
            "battery_value", "speed_value", "antilock_flag", "seatbelt_flag"};

        function new();
            phase         = SEEK_TYPE;
            kind_held     = KIND_TEMP;
            bytes_left    = '0;
            running_xor   = '0;
            last_payload  = '0;
            held_readings = '0;
            errors        = 0;
        endfunction

        // Advances the frame state by one byte; returns 1 when the byte was not dropped.
        function bit note_byte(logic [BYTE_W-1:0] b);
            frame_result_t fr;
            case (phase)
                SEEK_TYPE: begin
                    if (b >= TYPE_FIRST && b <= TYPE_LAST) begin
                        kind_held = KIND_W'(b - TYPE_FIRST);
                        phase     = TAKE_LEN;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                TAKE_LEN: begin
                    running_xor  = b;
                    bytes_left   = b;
                    last_payload = '0;
                    phase        = (b == '0) ? TAKE_CHECK : TAKE_DATA;
                end
                TAKE_DATA: begin
                    running_xor  = running_xor ^ b;
                    last_payload = b;
                    bytes_left   = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        phase = TAKE_CHECK;
                    end
                end
                default: begin
                    fr.kind = kind_held;
                    if (running_xor == b) begin
                        fr.status = STATUS_MATCH;
                        if (kind_held < KIND_COUNT) begin
                            held_readings[kind_held] = last_payload;
                        end
                    end else begin
                        fr.status = STATUS_MISMATCH;
                    end
                    fr.readings = held_readings;
                    expected_q.push_back(fr);
                    phase = SEEK_TYPE;
                end
            endcase
            return 1'b1;
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                         $time, got.kind, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: frame_kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: frame_status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            for (int i = 0; i < KIND_COUNT; i++) begin
                if (got.readings[i] !== want.readings[i]) begin
                    $display("%0t: %s expected 0x%02h actual 0x%02h", $time,
                             reading_names[i], want.readings[i], got.readings[i]);
                    errors++;
                end
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte;
    logic              m_valid;
    logic              m_ready;
    logic [KIND_W-1:0] m_frame_kind;
    logic              m_frame_status;
    logic [BYTE_W-1:0] m_temp_value;
    logic [BYTE_W-1:0] m_fuel_value;
    logic [BYTE_W-1:0] m_battery_value;
    logic [BYTE_W-1:0] m_speed_value;
    logic [BYTE_W-1:0] m_antilock_flag;
    logic [BYTE_W-1:0] m_seatbelt_flag;

    frame_scoreboard sb = new();
    int unsigned     used_bytes  = 0;
    int unsigned     burst_left  = 0;
    int unsigned     cycle_count = 0;
    int unsigned     stall_count = 0;
    ready_mode_t     ready_mode  = READY_ALWAYS;
    frame_result_t   seen;

    tlv_frame_xor_deframer_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_kind    (m_frame_kind),
        .m_frame_status  (m_frame_status),
        .m_temp_value    (m_temp_value),
        .m_fuel_value    (m_fuel_value),
        .m_battery_value (m_battery_value),
        .m_speed_value   (m_speed_value),
        .m_antilock_flag (m_antilock_flag),
        .m_seatbelt_flag (m_seatbelt_flag)
    );

    always #2 aclk = ~aclk;

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_byte(b)) begin
            used_bytes++;
        end
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] type_byte, input int unsigned len,
                              input bit bad_check, input bit truncate);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int unsigned       sent;
        sum  = BYTE_W'(len);
        sent = truncate ? $urandom_range(0, len) : len;
        put_byte(type_byte);
        put_byte(BYTE_W'(len));
        for (int i = 0; i < sent; i++) begin
            b = BYTE_W'($urandom_range(0, 255));
            sum ^= b;
            put_byte(b);
        end
        if (!truncate) begin
            put_byte(bad_check ? sum ^ BYTE_W'($urandom_range(1, 255)) : sum);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    function automatic int unsigned pick_length();
        return ($urandom_range(0, 39) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
    endfunction

    initial begin
        logic [BYTE_W-1:0] directed_bytes[$];
        int unsigned       sel;
        int unsigned       next_drain;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Dropped noise, then one frame per kind covering empty, full-scale and
        // type-valued payloads along with good and bad check bytes.
        directed_bytes = '{8'h00, 8'h1F, 8'h26, 8'hFF,
                           8'h20, 8'h00, 8'h00,
                           8'h21, 8'h01, 8'hFF, 8'hFE,
                           8'h22, 8'h02, 8'h25, 8'h20, 8'h07,
                           8'h25, 8'h00, 8'h01,
                           8'h23, 8'h01, 8'h80, 8'h81,
                           8'h24, 8'h01};
        foreach (directed_bytes[i]) begin
            put_byte(directed_bytes[i]);
        end
        put_byte(8'h7F);
        put_byte(8'h00);
        wait_for_results();

        send_frame(TYPE_FIRST + BYTE_W'($urandom_range(0, 5)), 255, 1'b0, 1'b0);
        next_drain = used_bytes + DRAIN_INTERVAL;
        while (used_bytes < TARGET_BYTES) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                send_frame(TYPE_FIRST + BYTE_W'($urandom_range(0, 5)), pick_length(),
                           $urandom_range(0, 3) == 0, 1'b0);
            end else if (sel < 90) begin
                put_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                send_frame(TYPE_FIRST + BYTE_W'($urandom_range(0, 5)), pick_length(),
                           1'b0, 1'b1);
            end
            if (used_bytes >= next_drain) begin
                wait_for_results();
                next_drain = used_bytes + DRAIN_INTERVAL;
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.kind                    = m_frame_kind;
            seen.status                  = m_frame_status;
            seen.readings[KIND_TEMP]     = m_temp_value;
            seen.readings[KIND_FUEL]     = m_fuel_value;
            seen.readings[KIND_BATTERY]  = m_battery_value;
            seen.readings[KIND_SPEED]    = m_speed_value;
            seen.readings[KIND_ANTILOCK] = m_antilock_flag;
            seen.readings[KIND_SEATBELT] = m_seatbelt_flag;
            sb.check_result(seen);
        end
        if (stall_count == 0) begin
            ready_mode  <= ready_mode_t'($urandom_range(0, 3));
            stall_count <= $urandom_range(50, 400);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (ready_mode)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_COIN:     m_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: m_ready <= (cycle_count % 5) < 2;
            default:        m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        m_ready <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/core/tfxd_pkg.sv
rtl/core/tfxd_front.sv
rtl/core/tfxd_queue.sv
rtl/core/tfxd_back.sv
rtl/core/tlv_frame_xor_deframer_unit.sv
rtl/core/tfxd_checker.sv
tb/tlv_frame_xor_deframer_unit_tb.sv
